### src/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
package qrs_pkg;

  // Coefficient and root word width
  localparam int unsigned CoefW = 32;
  // Exact radicand b*b - 4ac, signed
  localparam int unsigned RadW  = 68;
  // Numerator -b +/- sqrt, signed
  localparam int unsigned NumW  = 35;
  // Divisor 2|a|
  localparam int unsigned DmW   = 33;
  // Quotient bits formed by the divider
  localparam int unsigned QuoW  = 33;
  // Tolerance register reset value
  localparam logic [CoefW-1:0] BandReset = 32'd4295;

  typedef enum logic [1:0] {
    CntNone = 2'd0,
    CntOne  = 2'd1,
    CntTwo  = 2'd2
  } cnt_e;

  typedef struct packed {
    logic signed [CoefW-1:0] coef_a;
    logic signed [CoefW-1:0] coef_b;
    logic signed [CoefW-1:0] coef_c;
  } coef_t;

  typedef struct packed {
    logic [1:0]              root_count;
    logic signed [CoefW-1:0] root_first;
    logic signed [CoefW-1:0] root_second;
    logic                    fault;
  } root_t;

  // Sideband carried through the square root pipeline
  typedef struct packed {
    logic signed [CoefW-1:0] coef_a;
    logic signed [CoefW-1:0] coef_b;
    cnt_e                    cnt;
  } sq_tag_t;

endpackage

### src/qrs_radicand.sv
// Radicand pipeline: products, exact b*b-4ac, and root count decision.
module qrs_radicand (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  qrs_pkg::coef_t                  coef_i,
  input  logic [qrs_pkg::CoefW-1:0]       band_i,
  output logic                            valid_o,
  output qrs_pkg::cnt_e                   cnt_o,
  output logic [qrs_pkg::RadW-2:0]        rad_o,
  output logic signed [qrs_pkg::CoefW-1:0] a_o,
  output logic signed [qrs_pkg::CoefW-1:0] b_o
);
  import qrs_pkg::*;

  logic [2:0] v_q;

  logic [CoefW-1:0]          bm;
  logic [2*CoefW-1:0]        bsq_d, bsq_q;
  logic signed [2*CoefW-1:0] ac_d, ac_q;
  logic signed [CoefW-1:0]   a1_q, b1_q, a2_q, b2_q, a3_q, b3_q;

  logic signed [RadW-1:0] bsq_x, ac4_x, rad_d, rad_q;
  logic signed [RadW-1:0] band_x, lo_sum, hi_dif;
  cnt_e                   cnt_d, cnt_q;
  logic [RadW-2:0]        rad3_d, rad3_q;

  // Stage 1: square of |b| and product a*c
  assign bm    = coef_i.coef_b[CoefW-1] ? CoefW'(-coef_i.coef_b) : coef_i.coef_b;
  assign bsq_d = bm * bm;
  assign ac_d  = coef_i.coef_a * coef_i.coef_c;

  // Stage 2: exact radicand
  assign bsq_x = RadW'(bsq_q);
  assign ac4_x = RadW'(ac_q) <<< 2;
  assign rad_d = bsq_x - ac4_x;

  // Stage 3: compare against the tolerance band
  assign band_x = RadW'(band_i);
  assign lo_sum = rad_q + band_x;
  assign hi_dif = rad_q - band_x;

  always_comb begin
    if (lo_sum[RadW-1]) begin
      cnt_d = CntNone;
    end else if (hi_dif[RadW-1]) begin
      cnt_d = CntOne;
    end else begin
      cnt_d = CntTwo;
    end
    rad3_d = (cnt_d == CntTwo) ? rad_q[RadW-2:0] : '0;
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bsq_q  <= bsq_d;
      ac_q   <= ac_d;
      a1_q   <= coef_i.coef_a;
      b1_q   <= coef_i.coef_b;
      rad_q  <= rad_d;
      a2_q   <= a1_q;
      b2_q   <= b1_q;
      cnt_q  <= cnt_d;
      rad3_q <= rad3_d;
      a3_q   <= a2_q;
      b3_q   <= b2_q;
    end
  end

  assign valid_o = v_q[2];
  assign cnt_o   = cnt_q;
  assign rad_o   = rad3_q;
  assign a_o     = a3_q;
  assign b_o     = b3_q;

endmodule

### src/qrs_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module qrs_sqrt #(
  parameter int unsigned InW  = 67,
  parameter int unsigned TagW = 66
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [InW-1:0]          rad_i,
  input  logic [TagW-1:0]         tag_i,
  output logic                    valid_o,
  output logic [(InW+1)/2-1:0]    root_o,
  output logic [TagW-1:0]         tag_o
);

  localparam int unsigned OutW = (InW + 1) / 2;
  localparam int unsigned TW   = 2 * OutW + 1;

  logic [OutW:0]     v_q;
  logic [InW-1:0]    x_q   [0:OutW];
  logic [OutW-1:0]   s_q   [0:OutW];
  logic [TagW-1:0]   tag_q [0:OutW];

  // One restoring step: try setting bit k of the root
  function automatic logic [InW+OutW-1:0] sq_step(input logic [InW-1:0] x,
                                                  input logic [OutW-1:0] s,
                                                  input int k);
    logic [TW-1:0]   trial;
    logic [TW-1:0]   xw;
    logic [InW-1:0]  xn;
    logic [OutW-1:0] sn;
    trial = (TW'(s) << (k + 1)) | (TW'(1) << (2 * k));
    xw    = TW'(x);
    xn    = x;
    sn    = s;
    if (xw >= trial) begin
      xn = InW'(xw - trial);
      sn = s | (OutW'(1) << k);
    end
    return {xn, sn};
  endfunction

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[OutW-1:0], valid_i};
    end
  end

  // Capture, then resolve one bit per stage from the top
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= rad_i;
      s_q[0]   <= '0;
      tag_q[0] <= tag_i;
      for (int i = 0; i < OutW; i++) begin
        {x_q[i+1], s_q[i+1]} <= sq_step(x_q[i], s_q[i], OutW - 1 - i);
        tag_q[i+1]           <= tag_q[i];
      end
    end
  end

  assign valid_o = v_q[OutW];
  assign root_o  = s_q[OutW];
  assign tag_o   = tag_q[OutW];

endmodule

### src/qrs_div.sv
// Two-lane pipelined divider: num * 2^FracBits / (2a), truncated and saturated.
module qrs_div #(
  parameter int unsigned FracBits = 16,
  parameter int unsigned TagW     = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [qrs_pkg::NumW-1:0]   num1_i,
  input  logic signed [qrs_pkg::NumW-1:0]   num2_i,
  input  logic signed [qrs_pkg::CoefW-1:0]  a_i,
  input  logic [TagW-1:0]                   tag_i,
  output logic                              valid_o,
  output logic signed [qrs_pkg::CoefW-1:0]  root1_o,
  output logic signed [qrs_pkg::CoefW-1:0]  root2_o,
  output logic                              flt1_o,
  output logic                              flt2_o,
  output logic [TagW-1:0]                   tag_o
);
  import qrs_pkg::*;

  localparam int unsigned QB = QuoW;
  localparam int unsigned NW = NumW - 1 + FracBits;
  localparam int unsigned DW = (NW > DmW + QB) ? NW : DmW + QB;
  localparam logic [QB-1:0] NegLim = QB'(1) << (CoefW - 1);
  localparam logic [QB-1:0] PosLim = NegLim - QB'(1);

  logic [QB+1:0]    v_q;
  logic [DW-1:0]    rem_q [0:QB][0:1];
  logic [QB-1:0]    q_q   [0:QB][0:1];
  logic             neg_q [0:QB][0:1];
  logic             ovf_q [0:QB][0:1];
  logic [DmW-1:0]   dm_q  [0:QB];
  logic [QB:0]      dz_q;
  logic [TagW-1:0]  tag_q [0:QB+1];

  logic signed [NumW-1:0]  num [0:1];
  logic [CoefW-1:0]        am;
  logic [DmW-1:0]          dm_d;
  logic [DW-1:0]           dvd_d [0:1];
  logic                    neg_d [0:1];
  logic                    ovf_d [0:1];

  logic [CoefW-1:0] res_d [0:1];
  logic             flt_d [0:1];
  logic [CoefW-1:0] res_q [0:1];
  logic             flt_q [0:1];

  // One restoring step: quotient bit k
  function automatic logic [DW+QB-1:0] div_step(input logic [DW-1:0] rem,
                                                input logic [QB-1:0] q,
                                                input logic [DmW-1:0] dm,
                                                input int k);
    logic [DW-1:0] sub;
    logic [DW-1:0] rn;
    logic [QB-1:0] qn;
    sub = DW'(dm) << k;
    rn  = rem;
    qn  = q;
    if (rem >= sub) begin
      rn = rem - sub;
      qn = q | (QB'(1) << k);
    end
    return {rn, qn};
  endfunction

  assign num[0] = num1_i;
  assign num[1] = num2_i;
  assign am     = a_i[CoefW-1] ? CoefW'(-a_i) : a_i;
  assign dm_d   = DmW'(am) << 1;

  // Entry: magnitudes, sign, and early overflow check
  always_comb begin
    logic [NumW-1:0] nx;
    for (int l = 0; l < 2; l++) begin
      nx       = num[l][NumW-1] ? NumW'(-num[l]) : num[l];
      dvd_d[l] = DW'(nx[NumW-2:0]) << FracBits;
      neg_d[l] = num[l][NumW-1] ^ a_i[CoefW-1];
      ovf_d[l] = dvd_d[l] >= (DW'(dm_d) << QB);
    end
  end

  // Final: apply sign and saturate, or flag a zero divisor
  always_comb begin
    logic [QB-1:0] q;
    logic [QB-1:0] qn;
    for (int l = 0; l < 2; l++) begin
      q  = q_q[QB][l];
      qn = -q;
      if (dz_q[QB]) begin
        res_d[l] = '0;
        flt_d[l] = 1'b1;
      end else if (neg_q[QB][l]) begin
        if (ovf_q[QB][l] || q > NegLim) begin
          res_d[l] = {1'b1, {(CoefW-1){1'b0}}};
          flt_d[l] = 1'b1;
        end else begin
          res_d[l] = qn[CoefW-1:0];
          flt_d[l] = 1'b0;
        end
      end else begin
        if (ovf_q[QB][l] || q > PosLim) begin
          res_d[l] = {1'b0, {(CoefW-1){1'b1}}};
          flt_d[l] = 1'b1;
        end else begin
          res_d[l] = q[CoefW-1:0];
          flt_d[l] = 1'b0;
        end
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QB:0], valid_i};
    end
  end

  // Advance payload through entry, quotient bits and saturation
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        rem_q[0][l] <= dvd_d[l];
        q_q[0][l]   <= '0;
        neg_q[0][l] <= neg_d[l];
        ovf_q[0][l] <= ovf_d[l];
      end
      dm_q[0]  <= dm_d;
      dz_q[0]  <= (a_i == '0);
      tag_q[0] <= tag_i;
      for (int i = 0; i < QB; i++) begin
        for (int l = 0; l < 2; l++) begin
          {rem_q[i+1][l], q_q[i+1][l]} <=
            div_step(rem_q[i][l], q_q[i][l], dm_q[i], QB - 1 - i);
          neg_q[i+1][l] <= neg_q[i][l];
          ovf_q[i+1][l] <= ovf_q[i][l];
        end
        dm_q[i+1]  <= dm_q[i];
        dz_q[i+1]  <= dz_q[i];
        tag_q[i+1] <= tag_q[i];
      end
      for (int l = 0; l < 2; l++) begin
        res_q[l] <= res_d[l];
        flt_q[l] <= flt_d[l];
      end
      tag_q[QB+1] <= tag_q[QB];
    end
  end

  assign valid_o = v_q[QB+1];
  assign root1_o = res_q[0];
  assign root2_o = res_q[1];
  assign flt1_o  = flt_q[0];
  assign flt2_o  = flt_q[1];
  assign tag_o   = tag_q[QB+1];

endmodule

### src/qrs_skid.sv
// Output register with one skid entry, decoupling the pipeline from the consumer.
module qrs_skid (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  qrs_pkg::root_t  data_i,
  output logic            en_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output qrs_pkg::root_t  out_data_o
);
  import qrs_pkg::*;

  logic  out_v_q, skid_v_q;
  root_t out_q, skid_q;
  logic  hold;

  assign en_o = !skid_v_q;
  assign hold = out_v_q && !out_ready_i;

  // Track occupancy of the output and skid entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (hold) begin
      if (valid_i && !skid_v_q) begin
        skid_v_q <= 1'b1;
      end
    end else if (skid_v_q) begin
      out_v_q  <= 1'b1;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q <= valid_i;
    end
  end

  // Move words into the output or skid entry
  always_ff @(posedge clk_i) begin
    if (hold) begin
      if (!skid_v_q) begin
        skid_q <= data_i;
      end
    end else if (skid_v_q) begin
      out_q <= skid_q;
    end else begin
      out_q <= data_i;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

### src/quadratic_root_solver_core.sv
// Top level of the quadratic root solver.
//
//   channel | signals                          | word
//   --------+----------------------------------+-------------------------------
//   in      | in_valid_i / in_ready_o          | coef_t: coef_a, coef_b, coef_c
//   out     | out_valid_o / out_ready_i        | root_t: count, roots, fault
//   cfg     | cfg_valid_i / cfg_ready_o        | zero_band tolerance, 32 bits
//
// One word enters per cycle while in_ready_o is high; a result passes through the
// 34 square root stages and the 33 quotient-bit stages of the divider.
// Reset clears all valid bits and loads the default tolerance.
// A stalled output holds one result in the output register and one in the skid
// entry; the pipeline freezes only when both are full.
module quadratic_root_solver_core #(
  parameter int unsigned FracBits = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  qrs_pkg::coef_t              in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output qrs_pkg::root_t              out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [qrs_pkg::CoefW-1:0]   cfg_data_i
);
  import qrs_pkg::*;

  localparam int unsigned SqInW = RadW - 1;
  localparam int unsigned SqW   = (SqInW + 1) / 2;

  logic             en;
  logic [CoefW-1:0] band_q;

  logic                    rd_valid;
  cnt_e                    rd_cnt;
  logic [SqInW-1:0]        rd_rad;
  logic signed [CoefW-1:0] rd_a, rd_b;

  sq_tag_t          sq_tag_in, sq_tag_out;
  logic [$bits(sq_tag_t)-1:0] sq_tag_bits;
  logic             sq_valid;
  logic [SqW-1:0]   sq_root;

  logic signed [NumW-1:0]  bx, sx, n1_d, n2_d;
  logic                    nv_q;
  logic signed [NumW-1:0]  n1_q, n2_q;
  logic signed [CoefW-1:0] na_q;
  cnt_e                    ncnt_q;

  logic                    dv_valid;
  logic signed [CoefW-1:0] dv_r1, dv_r2;
  logic                    dv_f1, dv_f2;
  logic [1:0]              dv_tag;
  cnt_e                    dv_cnt;
  root_t                   res;

  // Tolerance register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q <= BandReset;
    end else if (cfg_valid_i) begin
      band_q <= cfg_data_i;
    end
  end

  assign in_ready_o = en;

  qrs_radicand u_rad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .coef_i  (in_data_i),
    .band_i  (band_q),
    .valid_o (rd_valid),
    .cnt_o   (rd_cnt),
    .rad_o   (rd_rad),
    .a_o     (rd_a),
    .b_o     (rd_b)
  );

  assign sq_tag_in  = '{coef_a: rd_a, coef_b: rd_b, cnt: rd_cnt};
  assign sq_tag_out = sq_tag_t'(sq_tag_bits);

  qrs_sqrt #(
    .InW  (SqInW),
    .TagW ($bits(sq_tag_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rd_valid),
    .rad_i   (rd_rad),
    .tag_i   (sq_tag_in),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .tag_o   (sq_tag_bits)
  );

  // Form the numerators -b + s and -b - s; with fewer than two roots the first is -b
  assign bx   = NumW'(sq_tag_out.coef_b);
  assign sx   = NumW'(sq_root);
  assign n1_d = (sq_tag_out.cnt == CntTwo) ? (sx - bx) : -bx;
  assign n2_d = -bx - sx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= 1'b0;
    end else if (en) begin
      nv_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q   <= n1_d;
      n2_q   <= n2_d;
      na_q   <= sq_tag_out.coef_a;
      ncnt_q <= sq_tag_out.cnt;
    end
  end

  qrs_div #(
    .FracBits (FracBits),
    .TagW     (2)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nv_q),
    .num1_i  (n1_q),
    .num2_i  (n2_q),
    .a_i     (na_q),
    .tag_i   (ncnt_q),
    .valid_o (dv_valid),
    .root1_o (dv_r1),
    .root2_o (dv_r2),
    .flt1_o  (dv_f1),
    .flt2_o  (dv_f2),
    .tag_o   (dv_tag)
  );

  // Drop unused roots according to the count
  assign dv_cnt = cnt_e'(dv_tag);
  always_comb begin
    res.root_count = dv_tag;
    case (dv_cnt)
      CntOne: begin
        res.root_first  = dv_r1;
        res.root_second = '0;
        res.fault       = dv_f1;
      end
      CntTwo: begin
        res.root_first  = dv_r1;
        res.root_second = dv_r2;
        res.fault       = dv_f1 | dv_f2;
      end
      default: begin
        res.root_first  = '0;
        res.root_second = '0;
        res.fault       = 1'b0;
      end
    endcase
  end

  qrs_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (dv_valid),
    .data_i      (res),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### src/qrs_checker.sv
// Port-level checks for the quadratic root solver, bound to the top level.
module qrs_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input qrs_pkg::root_t out_data_o
);
  import qrs_pkg::*;

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word dropped or changed while stalled");

  // No roots means zero roots and no fault
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.root_count == CntNone |->
      out_data_o.root_first == '0 && out_data_o.root_second == '0 && !out_data_o.fault)
    else $error("nonzero result with no roots");

  // A single root leaves the second slot empty
  a_one_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.root_count == CntOne |-> out_data_o.root_second == '0)
    else $error("second root set with one root");

  // The root count is always one of the three legal codes
  a_count_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.root_count == CntNone ||
      out_data_o.root_count == CntOne || out_data_o.root_count == CntTwo)
    else $error("illegal root count");

endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (.*);
